[rtl/core/gfr_pkg.sv]
// Shared types and constants for the gamepad frame receiver.
// No dependencies; every other file in rtl/core imports this package.
package gfr_pkg;

  localparam int PAYLOAD_LEN = 13;

  localparam logic [7:0] FRAME_HEAD   = 8'hAA;
  localparam logic [7:0] FRAME_TAIL   = 8'h55;
  localparam logic [7:0] PRESENT_MASK = 8'h01;

  localparam logic [4:0] POS_FIRST = 5'd1;
  localparam logic [4:0] POS_LAST  = 5'd13;
  localparam logic [4:0] POS_CHECK = 5'd14;
  localparam logic [4:0] POS_TAIL  = 5'd15;
  localparam logic [4:0] POS_IDLE  = 5'd16;

  localparam logic [15:0] IDLE_MAX = 16'hFFFF;

  localparam logic [14:0] DEADZONE_RESET = 15'd0;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd100;

  // Configuration register indexes
  localparam logic [1:0] CFG_DEADZONE = 2'd0;
  localparam logic [1:0] CFG_TIMEOUT  = 2'd1;

  typedef struct packed {
    logic       mode;
    logic [7:0] data_byte;
    logic       slice_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [15:0]        button_bits;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic               link_alive;
    logic               pad_connected;
    logic               frame_accepted;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_START,
    OP_BYTE
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } cmd_t;

  // Magnitudes strictly below the deadzone read as zero.
  function automatic logic [15:0] apply_deadzone(input logic [15:0] raw,
                                                 input logic [14:0] dz);
    logic signed [16:0] v;
    logic signed [16:0] d;
    begin
      v = {raw[15], raw};
      d = {2'b00, dz};
      if ((v > -d) && (v < d)) begin
        apply_deadzone = 16'd0;
      end else begin
        apply_deadzone = raw;
      end
    end
  endfunction

endpackage

[rtl/core/gfr_front.sv]
// Input side: takes items off the input channel and classifies them into
// tick / frame start / frame byte commands for the queue. Uses gfr_pkg.
module gfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  gfr_pkg::in_item_t in_item,
  input  logic              q_full,
  output logic              q_push,
  output gfr_pkg::cmd_t     q_cmd
);
  import gfr_pkg::*;

  logic seen_any;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_cmd.data = in_item.data_byte;
    if (in_item.mode) begin
      q_cmd.op = OP_TICK;
    end else if (in_item.slice_start) begin
      q_cmd.op = OP_START;
    end else begin
      q_cmd.op = OP_BYTE;
    end
  end

  // tracks whether any item has been taken since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any <= 1'b0;
    end else if (q_push) begin
      seen_any <= 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_push_no_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("push into full queue");
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> q_full) else $error("stall without full queue");
  a_seen: assert property (@(posedge clk) disable iff (rst)
    q_push |=> seen_any) else $error("item taken but not recorded");
`endif

endmodule

[rtl/core/gfr_queue.sv]
// Two-entry command queue between the front and the back.
// Uses gfr_pkg for the command type.
module gfr_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  gfr_pkg::cmd_t push_cmd,
  input  logic          pop,
  output gfr_pkg::cmd_t head_cmd,
  output logic          not_empty,
  output logic          full
);
  import gfr_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign head_cmd  = slots[rd_ptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3) else $error("queue count overflow");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr == rd_ptr) |-> (count == 2'd0 || count == 2'd2))
    else $error("pointers disagree with count");
`endif

endmodule

[rtl/core/gfr_back.sv]
// Back end: frame parser, committed pad state, idle timer, config registers
// and the output register. Uses gfr_pkg.
module gfr_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_not_empty,
  input  gfr_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gfr_pkg::out_item_t out_item
);
  import gfr_pkg::*;

  logic [14:0] deadzone;
  logic [15:0] timeout_ticks;

  logic [7:0]  frame_bytes [PAYLOAD_LEN];
  logic [4:0]  byte_pos, byte_pos_next;
  logic [7:0]  run_xor, run_xor_next;
  logic        ok, ok_next;
  logic [15:0] axis [4];
  logic [15:0] axis_next [4];
  logic [15:0] buttons, buttons_next;
  logic [7:0]  trig_l, trig_l_next;
  logic [7:0]  trig_r, trig_r_next;
  logic        present, present_next;
  logic        alive, alive_next;
  logic [15:0] idle_count, idle_count_next;
  logic        shift_en;
  logic        commit;
  logic        connected;
  out_item_t   result;

  assign cfg_ready = 1'b1;
  assign q_pop = q_not_empty && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone      <= DEADZONE_RESET;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEADZONE: deadzone      <= cfg_data[14:0];
        CFG_TIMEOUT:  timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    byte_pos_next   = byte_pos;
    run_xor_next    = run_xor;
    ok_next         = ok;
    buttons_next    = buttons;
    trig_l_next     = trig_l;
    trig_r_next     = trig_r;
    present_next    = present;
    alive_next      = alive;
    idle_count_next = idle_count;
    shift_en        = 1'b0;
    commit          = 1'b0;
    for (int k = 0; k < 4; k++) begin
      axis_next[k] = axis[k];
    end

    if (q_pop) begin
      case (q_cmd.op)
        OP_TICK: begin
          if (idle_count != IDLE_MAX) begin
            idle_count_next = idle_count + 16'd1;
          end
        end
        OP_START: begin
          ok_next       = (q_cmd.data == FRAME_HEAD);
          run_xor_next  = 8'd0;
          byte_pos_next = POS_FIRST;
        end
        OP_BYTE: begin
          if (byte_pos inside {[POS_FIRST:POS_LAST]}) begin
            shift_en      = 1'b1;
            run_xor_next  = run_xor ^ q_cmd.data;
            byte_pos_next = byte_pos + 5'd1;
          end else if (byte_pos == POS_CHECK) begin
            ok_next       = ok && (q_cmd.data == run_xor);
            byte_pos_next = POS_TAIL;
          end else if (byte_pos == POS_TAIL) begin
            byte_pos_next = POS_IDLE;
            commit        = ok && (q_cmd.data == FRAME_TAIL);
          end else begin
            byte_pos_next = POS_IDLE;
          end
        end
        default: ;
      endcase

      if (commit) begin
        for (int k = 0; k < 4; k++) begin
          axis_next[k] = {frame_bytes[2*k], frame_bytes[2*k+1]};
        end
        buttons_next    = {frame_bytes[8], frame_bytes[9]};
        trig_l_next     = frame_bytes[10];
        trig_r_next     = frame_bytes[11];
        present_next    = |(frame_bytes[12] & PRESENT_MASK);
        alive_next      = 1'b1;
        idle_count_next = 16'd0;
      end

      if (alive_next && (idle_count_next > timeout_ticks)) begin
        alive_next   = 1'b0;
        present_next = 1'b0;
      end
    end

    connected = alive_next && present_next;
    result.left_x  = connected ? apply_deadzone(axis_next[0], deadzone) : 16'd0;
    result.left_y  = connected ? apply_deadzone(axis_next[1], deadzone) : 16'd0;
    result.right_x = connected ? apply_deadzone(axis_next[2], deadzone) : 16'd0;
    result.right_y = connected ? apply_deadzone(axis_next[3], deadzone) : 16'd0;
    result.button_bits    = connected ? buttons_next : 16'd0;
    result.left_trigger   = connected ? trig_l_next : 8'd0;
    result.right_trigger  = connected ? trig_r_next : 8'd0;
    result.link_alive     = alive_next;
    result.pad_connected  = connected;
    result.frame_accepted = commit;
  end

  // payload shift line: after 13 bytes, entry 0 holds frame byte 1
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < PAYLOAD_LEN - 1; k++) begin
        frame_bytes[k] <= frame_bytes[k+1];
      end
      frame_bytes[PAYLOAD_LEN-1] <= q_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos   <= POS_IDLE;
      run_xor    <= 8'd0;
      ok         <= 1'b0;
      buttons    <= 16'd0;
      trig_l     <= 8'd0;
      trig_r     <= 8'd0;
      present    <= 1'b0;
      alive      <= 1'b0;
      idle_count <= 16'd0;
      for (int k = 0; k < 4; k++) begin
        axis[k] <= 16'd0;
      end
    end else begin
      byte_pos   <= byte_pos_next;
      run_xor    <= run_xor_next;
      ok         <= ok_next;
      buttons    <= buttons_next;
      trig_l     <= trig_l_next;
      trig_r     <= trig_r_next;
      present    <= present_next;
      alive      <= alive_next;
      idle_count <= idle_count_next;
      for (int k = 0; k < 4; k++) begin
        axis[k] <= axis_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item <= result;
    end
  end

`ifndef SYNTHESIS
  a_conn_alive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.pad_connected) |-> out_item.link_alive)
    else $error("pad connected without link");
  a_accept_alive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.frame_accepted) |-> out_item.link_alive)
    else $error("accepted frame did not raise link");
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    (byte_pos != 5'd0) && (byte_pos <= POS_IDLE))
    else $error("byte position out of range");
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    commit |=> (idle_count == 16'd0) && alive)
    else $error("commit did not reset idle timer");
`endif

endmodule

[rtl/core/gamepad_frame_receiver.sv]
// Gamepad frame receiver: one item per cycle sustained through the command
// queue and the back end while out_stall is low; each item taken is written
// to a queue slot, then popped by the back end into the output register.
// Reset (synchronous, active high) clears the parser, pad state, idle timer
// and queue; deadzone returns to 0 and the timeout to 100 ticks.
// Depends on gfr_pkg, gfr_front, gfr_queue, gfr_back.
module gamepad_frame_receiver (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  gfr_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output gfr_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import gfr_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_not_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  gfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  gfr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_cmd  (push_cmd),
    .pop       (q_pop),
    .head_cmd  (head_cmd),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  gfr_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_cmd       (head_cmd),
    .q_pop       (q_pop),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule
